>>> rtl/core/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Shared payload types, the S-box table and the round helper functions.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int NumRounds = 10;

  typedef struct packed {
    logic [63:0] plaintext_hi;
    logic [63:0] plaintext_lo;
    logic [63:0] cipher_key_hi;
    logic [63:0] cipher_key_lo;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] ciphertext_hi;
    logic [63:0] ciphertext_lo;
  } aes_out_t;

  // Forward S-box, indexed by the input byte.
  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Round constants for rounds 1 to 10.
  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes and ShiftRows; byte n sits at bits 127-8n.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (c * 4 + r) -: 8] = SBOX[s[127 - 8 * (((c + r) % 4) * 4 + r) -: 8]];
      end
    end
    return t;
  endfunction

  // MixColumns over the four columns.
  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // Next round key from the previous one.
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

>>> rtl/core/aes128_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// AES-128 block encryption top level
// Fully unrolled round pipeline with on-the-fly key expansion.
// ----------------------------------------------------------------------------
// Usage:
//   A transfer in takes place at a rising edge where start is high and busy
//   is low. The input struct carries the plaintext and the cipher key, both
//   in message byte order. busy is always low, so one block may enter in
//   every cycle.
//   Each ciphertext leaves on result with done high for exactly one cycle,
//   after passing through one stage for the initial key add and one stage
//   for each of the ten rounds, each round stage holding one S-box layer
//   plus its key step.
//   Throughput is one block per cycle, set by the one-round-per-stage
//   pipeline. Blocks leave in the order they entered.
//   Reset clears the valid bits of every stage; data registers are not reset.
//   The receiver cannot stall, so the pipeline never holds.
module aes128_block_encrypt_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  aes_pkg::aes_in_t data,
  output logic             busy,
  output logic             done,
  output aes_pkg::aes_out_t result
);
  import aes_pkg::*;

  logic [127:0] state [NumRounds + 1];
  logic [127:0] rkey  [NumRounds + 1];
  logic         valid [NumRounds + 1];

  assign busy = 1'b0;

  // Stage 0: initial AddRoundKey.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= start;
    end
    state[0] <= {data.plaintext_hi, data.plaintext_lo} ^
                {data.cipher_key_hi, data.cipher_key_lo};
    rkey[0]  <= {data.cipher_key_hi, data.cipher_key_lo};
  end

  // Round stages; the last one skips MixColumns.
  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    logic [127:0] key_n;
    logic [127:0] sub_s;
    assign key_n = next_key(rkey[g - 1], RCON[g - 1]);
    assign sub_s = sub_shift(state[g - 1]);
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[g] <= 1'b0;
      end else begin
        valid[g] <= valid[g - 1];
      end
      rkey[g] <= key_n;
      if (g == NumRounds) begin
        state[g] <= sub_s ^ key_n;
      end else begin
        state[g] <= mix_columns(sub_s) ^ key_n;
      end
    end
  end

  // Output.
  assign done                 = valid[NumRounds];
  assign result.ciphertext_hi = state[NumRounds][127:64];
  assign result.ciphertext_lo = state[NumRounds][63:0];

`ifndef SYNTH
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(valid[NumRounds - 1]))
    else $error("done without a valid final round");
  a_start_lands: assert property (@(posedge clk) disable iff (rst)
    start ##1 !rst |-> valid[0])
    else $error("accepted block lost at stage 0");
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
`endif

endmodule
